>>> hdl/p256_inv_pkg.sv
// Package for the P-256 field inverter: field constants, the exponent
// schedule and shared types. No dependencies.
package p256_inv_pkg;

    localparam int unsigned FieldW    = 256;
    localparam int unsigned LimbW     = 64;
    localparam int unsigned LimbCount = 4;
    localparam logic [FieldW-1:0] Prime =
        256'hffffffff00000001000000000000000000000000ffffffffffffffffffffffff;

    // The chain computes x^(p-2). A plain left-to-right square and multiply
    // over the exponent gives the same value, since every product here is a
    // fully reduced Montgomery product and the exponent is fixed.
    localparam logic [FieldW-1:0] ExpPm2 = Prime - 256'd2;

    typedef struct packed {
        logic start;
        logic done;
    } t_mul_ctl;

endpackage

>>> hdl/p256_inv_mont.sv
// Bit-serial Montgomery multiplier modulo the P-256 prime with R = 2^256.
// Depends on p256_inv_pkg.
module p256_inv_mont
    import p256_inv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FieldW-1:0] i_a,
    input  logic [FieldW-1:0] i_b,
    output logic              o_done,
    output logic [FieldW-1:0] o_r
);

    // One bit of a per cycle: t = (t + a_i*b + q*p) / 2, then a final
    // conditional subtraction. t stays below 2p throughout.
    logic [FieldW-1:0] r_a, n_a;
    logic [FieldW-1:0] r_b;
    logic [FieldW+1:0] r_t, n_t;
    logic [8:0]        r_cnt;
    logic              r_busy, r_fin;
    logic [FieldW+1:0] w_s1, w_s2;
    logic [FieldW+1:0] w_sub;

    always_comb begin
        w_s1  = r_t + (r_a[0] ? {2'b00, r_b} : '0);
        w_s2  = w_s1 + (w_s1[0] ? {2'b00, Prime} : '0);
        n_t   = w_s2 >> 1;
        n_a   = r_a >> 1;
        w_sub = r_t - {2'b00, Prime};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 9'd1;
                if (r_cnt == 9'(FieldW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_t <= '0;
        end else if (r_busy) begin
            r_a <= n_a;
            r_t <= n_t;
        end else if (r_fin) begin
            if (!w_sub[FieldW+1]) r_t <= w_sub;
        end
    end

    assign o_done = r_fin;
    assign o_r    = (!w_sub[FieldW+1]) ? w_sub[FieldW-1:0] : r_t[FieldW-1:0];

endmodule

>>> hdl/p256_field_inverse_top.sv
// Top level of the P-256 field inverter: limb collection, exponent
// sequencer and limb output. Depends on p256_inv_pkg and p256_inv_mont.
//
// The block takes one field element in Montgomery form as four 64-bit
// transactions, least significant limb first, and returns its inverse
// (also Montgomery form, fully reduced) as four transactions with o_last
// high on the fourth. The inverse is x^(p-2), formed by square and
// multiply over the 256 exponent bits on one bit-serial Montgomery
// multiplier; each product is issued once the last one is done. The
// exponent has 127 one bits below its top bit, so an inversion takes 255
// squarings plus 127 multiplications, 382 products in all, and that
// multiplier sets the rate. An operand at or above p is reduced once
// before the first product. A zero operand (or one equal to p) yields
// zero. One element is processed at a time; input is held off while the
// chain runs and while result limbs wait to be taken.
module p256_field_inverse_top
    import p256_inv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [LimbW-1:0] i_in_limb,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [LimbW-1:0] o_out_limb,
    output logic             o_last
);

    localparam int CntW = $clog2(LimbCount);

    typedef enum logic [4:0] {
        S_COLLECT = 5'b00001,
        S_LOAD    = 5'b00010,
        S_SQR     = 5'b00100,
        S_MUL     = 5'b01000,
        S_OUT     = 5'b10000
    } t_state;

    t_state            r_state;
    logic [CntW-1:0]   r_cnt;
    logic [FieldW-1:0] r_x, r_acc, r_res;
    logic [7:0]        r_bit;
    logic              r_issue;
    t_mul_ctl          w_ctl;
    logic              w_done;
    logic [FieldW-1:0] w_r, w_xr, w_mb;

    assign w_xr  = (r_x >= Prime) ? r_x - Prime : r_x;
    assign w_mb  = (r_state == S_SQR) ? r_acc : w_xr;
    assign w_ctl = {r_issue, w_done};

    p256_inv_mont u_mont (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_ctl.start),
        .i_a    (r_acc),
        .i_b    (w_mb),
        .o_done (w_done),
        .o_r    (w_r)
    );

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_limb  = r_res[LimbW-1:0];
    assign o_last      = (r_cnt == CntW'(LimbCount - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_cnt   <= '0;
            r_issue <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_issue <= 1'b0;
            unique case (r_state)
                S_COLLECT: begin
                    if (i_in_valid) begin
                        r_x <= {i_in_limb, r_x[FieldW-1:LimbW]};
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CntW'(LimbCount - 1)) begin
                            r_bit   <= 8'(FieldW - 2);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    // Top exponent bit is one: acc starts as the reduced x.
                    r_acc   <= w_xr;
                    r_issue <= 1'b1;
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    if (w_ctl.done) begin
                        r_acc   <= w_r;
                        r_issue <= 1'b1;
                        if (ExpPm2[r_bit]) begin
                            r_state <= S_MUL;
                        end else if (r_bit == '0) begin
                            r_issue <= 1'b0;
                            r_res   <= w_r;
                            r_state <= S_OUT;
                        end else begin
                            r_bit <= r_bit - 8'd1;
                        end
                    end
                end
                S_MUL: begin
                    if (w_ctl.done) begin
                        r_acc <= w_r;
                        if (r_bit == '0) begin
                            r_res   <= w_r;
                            r_state <= S_OUT;
                        end else begin
                            r_bit   <= r_bit - 8'd1;
                            r_issue <= 1'b1;
                            r_state <= S_SQR;
                        end
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_res <= r_res >> LimbW;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CntW'(LimbCount - 1)) r_state <= S_COLLECT;
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_issue_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_issue) else $error("product started during output");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_limb))
        else $error("result limb changed while stalled");

endmodule
